// ===== rtl/core/dfu_rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dfu_rsm_pkg
// Types and codes shared by the DFU class request state machine.
// ----------------------------------------------------------------------------
package dfu_rsm_pkg;

  typedef enum logic [2:0] {
    OP_DETACH    = 3'd0,
    OP_DNLOAD    = 3'd1,
    OP_UPLOAD    = 3'd2,
    OP_GETSTATUS = 3'd3,
    OP_CLRSTATUS = 3'd4,
    OP_GETSTATE  = 3'd5,
    OP_ABORT     = 3'd6,
    OP_UNKNOWN   = 3'd7
  } dfu_op_e;

  typedef enum logic [3:0] {
    ST_APP_IDLE      = 4'd0,
    ST_APP_DETACH    = 4'd1,
    ST_DFU_IDLE      = 4'd2,
    ST_DN_SYNC       = 4'd3,
    ST_DN_BUSY       = 4'd4,
    ST_DN_IDLE       = 4'd5,
    ST_MAN_SYNC      = 4'd6,
    ST_MANIFEST      = 4'd7,
    ST_MAN_WAIT_RST  = 4'd8,
    ST_UP_IDLE       = 4'd9,
    ST_ERROR         = 4'd10
  } dfu_state_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_STATUS = 3'd1,
    KIND_STATE  = 3'd2,
    KIND_UPLOAD = 3'd3,
    KIND_DNLOAD = 3'd4
  } xfer_kind_e;

  // bStatus codes
  localparam logic [3:0] ERR_NONE       = 4'h0;
  localparam logic [3:0] ERR_UNKNOWN    = 4'hE;
  localparam logic [3:0] ERR_STALLEDPKT = 4'hF;

  // Fixed EP0 reply sizes
  localparam logic [15:0] STATUS_LEN = 16'd6;
  localparam logic [15:0] STATE_LEN  = 16'd1;

  typedef struct packed {
    dfu_op_e     operation;
    logic [15:0] request_length;
    logic        media_ok;
    logic [15:0] media_length;
  } dfu_req_t;

  typedef struct packed {
    logic        stall_res;
    xfer_kind_e  transfer_kind;
    logic [15:0] transfer_length;
    logic [3:0]  reply_status;
    logic [3:0]  reply_state;
    logic        poll_timeout;
    logic        detach_seen;
  } dfu_rsp_t;

  function automatic logic state_is_abortable(dfu_state_e s);
    return (s == ST_DFU_IDLE) || (s == ST_DN_SYNC) || (s == ST_DN_IDLE) ||
           (s == ST_MAN_SYNC) || (s == ST_UP_IDLE);
  endfunction

endpackage

// ===== rtl/core/dfu_request_state_machine.sv =====
// ----------------------------------------------------------------------------
// dfu_request_state_machine
// DFU class request handler: checks each request against the DFU state,
// updates state, bStatus and the sticky detach flag, and returns one response.
// ----------------------------------------------------------------------------
//
//  channel | dir | signals                          | payload
//  --------+-----+----------------------------------+-----------------------
//  request | in  | req_valid_i / req_ready_o        | req_i  (dfu_req_t)
//  reply   | out | rsp_valid_o / rsp_ready_i        | rsp_o  (dfu_rsp_t)
//
//  - One request per cycle while replies are taken: the whole decision is one
//    level of compares and muxes ahead of the response register.
//  - State, bStatus and detach flag update at the edge that accepts a request;
//    the response for that request is in rsp_o from the next cycle.
//  - The response register frees up in the cycle it is taken, so a new
//    request is accepted while rsp_ready_i is high or the register is empty.
//  - A stalled reply holds the register and blocks new requests.
//  - Reset (rst_ni low, async) returns to dfuIDLE, no error, no detach.
//
module dfu_request_state_machine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  dfu_rsm_pkg::dfu_req_t req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output dfu_rsm_pkg::dfu_rsp_t rsp_o
);
  import dfu_rsm_pkg::*;

  dfu_state_e state_q, state_d;
  logic [3:0] err_q, err_d;
  logic       detach_q, detach_d;
  logic       rsp_valid_q, rsp_valid_d;
  dfu_rsp_t   rsp_q, rsp_d;
  logic       req_fire;

  // Response slot is free when empty or being drained this cycle.
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign req_fire    = req_valid_i && req_ready_o;

  // --------------------------------------------------------------------------
  // Next state: state, bStatus and detach flag
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    err_d    = err_q;
    detach_d = detach_q;
    if (req_fire) begin
      case (req_i.operation)
        OP_DETACH: begin
          if (state_is_abortable(state_q)) begin
            state_d = ST_DFU_IDLE;
            err_d   = ERR_NONE;
          end
          detach_d = 1'b1;
        end
        OP_DNLOAD: begin
          if (req_i.request_length != '0) begin
            // data block: only from dfuIDLE / dfuDNLOAD-IDLE with media ok
            if ((state_q == ST_DFU_IDLE || state_q == ST_DN_IDLE) && req_i.media_ok) begin
              state_d = ST_DN_SYNC;
            end
          end else if (state_q == ST_DN_IDLE) begin
            // zero length ends the download; manifest even if the step fails
            state_d = ST_MAN_SYNC;
          end
        end
        OP_UPLOAD: begin
          if (req_i.request_length == '0) begin
            state_d = ST_DFU_IDLE;
          end else if (state_q == ST_DFU_IDLE || state_q == ST_UP_IDLE) begin
            if (req_i.media_ok) begin
              // short frame ends the upload
              state_d = (req_i.request_length > req_i.media_length) ? ST_DFU_IDLE
                                                                    : ST_UP_IDLE;
            end else begin
              state_d = ST_ERROR;
              err_d   = ERR_STALLEDPKT;
            end
          end
        end
        OP_GETSTATUS: begin
          if (state_q == ST_DN_SYNC) begin
            state_d = ST_DN_IDLE;
          end else if (state_q == ST_MAN_SYNC) begin
            state_d = ST_DFU_IDLE;
          end
        end
        OP_CLRSTATUS: begin
          if (state_q == ST_ERROR) begin
            state_d = ST_DFU_IDLE;
            err_d   = ERR_NONE;
          end else begin
            state_d = ST_ERROR;
            err_d   = ERR_UNKNOWN;
          end
        end
        OP_ABORT: begin
          if (state_is_abortable(state_q)) begin
            state_d = ST_DFU_IDLE;
            err_d   = ERR_NONE;
          end
        end
        default: begin
          // getstate and unknown requests leave the state alone
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Response fields (from the state before the transition)
  // --------------------------------------------------------------------------
  always_comb begin
    rsp_d                 = '0;
    rsp_d.transfer_kind   = KIND_NONE;
    rsp_d.detach_seen     = detach_d;
    case (req_i.operation)
      OP_DETACH, OP_CLRSTATUS, OP_ABORT: begin
        // no transfer, never stalls
      end
      OP_DNLOAD: begin
        if (req_i.request_length != '0) begin
          if ((state_q == ST_DFU_IDLE || state_q == ST_DN_IDLE) && req_i.media_ok) begin
            rsp_d.transfer_kind   = KIND_DNLOAD;
            rsp_d.transfer_length = req_i.media_length;
          end else begin
            rsp_d.stall_res = 1'b1;
          end
        end else begin
          rsp_d.stall_res = (state_q != ST_DN_IDLE) || !req_i.media_ok;
        end
      end
      OP_UPLOAD: begin
        if (req_i.request_length != '0) begin
          if ((state_q == ST_DFU_IDLE || state_q == ST_UP_IDLE) && req_i.media_ok) begin
            rsp_d.transfer_kind   = KIND_UPLOAD;
            rsp_d.transfer_length = req_i.media_length;
          end else begin
            rsp_d.stall_res = 1'b1;
          end
        end
      end
      OP_GETSTATUS: begin
        rsp_d.transfer_kind   = KIND_STATUS;
        rsp_d.transfer_length = STATUS_LEN;
        rsp_d.reply_status    = err_q;
        rsp_d.reply_state     = 4'(state_q);
        if (state_q == ST_MAN_SYNC) begin
          // manifestation reported as in progress with a 1 ms poll
          rsp_d.reply_state  = 4'(ST_MANIFEST);
          rsp_d.poll_timeout = 1'b1;
        end
      end
      OP_GETSTATE: begin
        rsp_d.transfer_kind   = KIND_STATE;
        rsp_d.transfer_length = STATE_LEN;
        rsp_d.reply_state     = 4'(state_q);
      end
      default: begin
        rsp_d.stall_res = 1'b1;
      end
    endcase
  end

  assign rsp_valid_d = req_fire || (rsp_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DFU_IDLE;
      err_q       <= ERR_NONE;
      detach_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      detach_q    <= detach_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_fire_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> rsp_valid_q)
    else $error("accepted request produced no response");

  a_detach_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.operation == OP_DETACH) |=> (detach_q && rsp_q.detach_seen))
    else $error("detach flag not set after detach request");

  a_error_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERROR) |-> (err_q != ERR_NONE))
    else $error("dfuERROR without bStatus code");

  a_stall_no_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.stall_res) |-> (rsp_q.transfer_kind == KIND_NONE))
    else $error("stalled request carries a transfer");

  a_poll_manifest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.poll_timeout) |->
      (rsp_q.reply_state == 4'(ST_MANIFEST) && rsp_q.transfer_kind == KIND_STATUS))
    else $error("poll timeout outside manifestation status");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DFU class request state machine. A behavioral
// model predicts the reply to every accepted request. Each reply taken from
// the block is checked against the oldest prediction. Traffic is a directed
// walk through the state table, then random download, upload and recovery
// sessions with noise mixed in, under changing idle patterns and one long
// reply-side hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfu_rsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYC  = 4;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready_o;
  dfu_req_t req = '0;
  logic     rsp_valid_o;
  logic     rsp_ready = 1'b0;
  dfu_rsp_t rsp_o;

  dfu_request_state_machine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready_o),
    .req_i       (req),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_o)
  );

  always #6 clk = ~clk;

  // Model state, updated at the edge where the block takes a request.
  dfu_state_e model_state  = ST_DFU_IDLE;
  logic [3:0] model_error  = ERR_NONE;
  logic       model_detach = 1'b0;

  dfu_rsp_t pending_replies[$];

  int fail_count   = 0;
  int sent_count   = 0;
  int cycle_count  = 0;
  int req_idle_pct = 0;   // read only by the sending process
  int rsp_idle_pct = 0;   // written with NBAs, read by the reply process
  int hold_tickets = 0;   // each bump asks the reply side for one long hold-off

  // --------------------------------------------------------------------------
  // Behavioral model
  // --------------------------------------------------------------------------
  // States from which detach and abort return to dfuIDLE.
  function automatic bit can_abort(dfu_state_e s);
    return s == ST_DFU_IDLE || s == ST_DN_SYNC || s == ST_DN_IDLE ||
           s == ST_MAN_SYNC || s == ST_UP_IDLE;
  endfunction

  // Predicts the reply to one request and advances the model state.
  function dfu_rsp_t dfu_apply_request(dfu_req_t r);
    dfu_rsp_t p;
    p = '0;
    p.transfer_kind = KIND_NONE;
    case (r.operation)
      OP_DETACH: begin
        if (can_abort(model_state)) begin
          model_state = ST_DFU_IDLE;
          model_error = ERR_NONE;
        end
        model_detach = 1'b1;
      end
      OP_DNLOAD: begin
        if (r.request_length != 16'd0) begin
          if (model_state != ST_DFU_IDLE && model_state != ST_DN_IDLE) begin
            p.stall_res = 1'b1;
          end else if (r.media_ok) begin
            model_state       = ST_DN_SYNC;
            p.transfer_kind   = KIND_DNLOAD;
            p.transfer_length = r.media_length;
          end else begin
            p.stall_res = 1'b1;
          end
        end else if (model_state != ST_DN_IDLE) begin
          p.stall_res = 1'b1;
        end else begin
          // zero-length download starts manifestation; a failed step still
          // leaves the state in manifest-sync
          model_state = ST_MAN_SYNC;
          p.stall_res = !r.media_ok;
        end
      end
      OP_UPLOAD: begin
        if (r.request_length == 16'd0) begin
          model_state = ST_DFU_IDLE;
        end else if (model_state != ST_DFU_IDLE && model_state != ST_UP_IDLE) begin
          p.stall_res = 1'b1;
        end else if (r.media_ok) begin
          // short frame ends the upload
          model_state = (r.request_length > r.media_length) ? ST_DFU_IDLE : ST_UP_IDLE;
          p.transfer_kind   = KIND_UPLOAD;
          p.transfer_length = r.media_length;
        end else begin
          model_state = ST_ERROR;
          model_error = ERR_STALLEDPKT;
          p.stall_res = 1'b1;
        end
      end
      OP_GETSTATUS: begin
        p.transfer_kind   = KIND_STATUS;
        p.transfer_length = STATUS_LEN;
        p.reply_status    = model_error;
        p.reply_state     = model_state;
        if (model_state == ST_DN_SYNC) begin
          model_state = ST_DN_IDLE;
        end else if (model_state == ST_MAN_SYNC) begin
          p.reply_state  = ST_MANIFEST;
          p.poll_timeout = 1'b1;
          model_state    = ST_DFU_IDLE;
        end
      end
      OP_CLRSTATUS: begin
        if (model_state == ST_ERROR) begin
          model_state = ST_DFU_IDLE;
          model_error = ERR_NONE;
        end else begin
          model_state = ST_ERROR;
          model_error = ERR_UNKNOWN;
        end
      end
      OP_GETSTATE: begin
        p.transfer_kind   = KIND_STATE;
        p.transfer_length = STATE_LEN;
        p.reply_state     = model_state;
      end
      OP_ABORT: begin
        if (can_abort(model_state)) begin
          model_state = ST_DFU_IDLE;
          model_error = ERR_NONE;
        end
      end
      default: begin
        p.stall_res = 1'b1;
      end
    endcase
    p.detach_seen = model_detach;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check replies taken, then predict for the request taken.
  // Both sampled at the rising edge, before any NBA of that step lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    dfu_rsp_t want;
    if (rst_n) begin
      if (rsp_valid_o && rsp_ready) begin
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("[%0t] reply with no request outstanding", $realtime);
        end else begin
          want = pending_replies.pop_front();
          if (rsp_o.stall_res       !== want.stall_res       ||
              rsp_o.transfer_kind   !== want.transfer_kind   ||
              rsp_o.transfer_length !== want.transfer_length ||
              rsp_o.reply_status    !== want.reply_status    ||
              rsp_o.reply_state     !== want.reply_state     ||
              rsp_o.poll_timeout    !== want.poll_timeout    ||
              rsp_o.detach_seen     !== want.detach_seen) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("[%0t] mismatch", $realtime);
              $display("  exp: stall=%0d kind=%0d len=%0d sts=%0h st=%0d poll=%0d det=%0d",
                       want.stall_res, want.transfer_kind,
                       want.transfer_length, want.reply_status, want.reply_state,
                       want.poll_timeout, want.detach_seen);
              $display("  act: stall=%0d kind=%0d len=%0d sts=%0h st=%0d poll=%0d det=%0d",
                       rsp_o.stall_res, rsp_o.transfer_kind, rsp_o.transfer_length,
                       rsp_o.reply_status, rsp_o.reply_state, rsp_o.poll_timeout,
                       rsp_o.detach_seen);
            end
          end
        end
      end
      if (req_valid && req_ready_o)
        pending_replies.push_back(dfu_apply_request(req));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Reply side: random ready, or a long hold-off when a ticket comes in.
  // --------------------------------------------------------------------------
  initial begin
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_tickets != served) begin
        served    = hold_tickets;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic dfu_req_t make_req(dfu_op_e op, logic [15:0] rlen, logic ok,
                                        logic [15:0] mlen);
    dfu_req_t r;
    r.operation      = op;
    r.request_length = rlen;
    r.media_ok       = ok;
    r.media_length   = mlen;
    return r;
  endfunction

  // Nonzero length, mostly short, now and then anywhere in 16 bits.
  function automatic logic [15:0] rand_len();
    if ($urandom_range(9) == 0)
      return 16'($urandom_range(65535, 1));
    return 16'($urandom_range(64, 1));
  endfunction

  function automatic dfu_req_t rand_req();
    return make_req(dfu_op_e'(3'($urandom_range(7))), 16'($urandom),
                    1'($urandom), 16'($urandom));
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  // Valid is dropped only when an idle gap is inserted.
  task automatic send_request(dfu_req_t r);
    int idle;
    idle = 0;
    while ($urandom_range(99) < req_idle_pct && idle < 40)
      idle++;
    if (idle != 0) begin
      req_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready_o) @(posedge clk);
    sent_count++;
  endtask

  // Upload of zero length returns to dfuIDLE from any state: a clean start.
  task automatic send_restart();
    send_request(make_req(OP_UPLOAD, 16'd0, 1'($urandom), 16'($urandom)));
  endtask

  // Status poll, sometimes preceded by a state read.
  task automatic send_poll();
    if ($urandom_range(4) == 0)
      send_request(make_req(OP_GETSTATE, 16'($urandom), 1'($urandom), 16'($urandom)));
    send_request(make_req(OP_GETSTATUS, 16'($urandom), 1'($urandom), 16'($urandom)));
  endtask

  task automatic send_download_session();
    int blocks;
    blocks = $urandom_range(6, 1);
    send_restart();
    repeat (blocks) begin
      send_request(make_req(OP_DNLOAD, rand_len(), $urandom_range(19) != 0,
                            16'($urandom)));
      if ($urandom_range(19) == 0)
        send_request(rand_req());
      send_poll();
    end
    // end of image: manifestation and its poll
    send_request(make_req(OP_DNLOAD, 16'd0, $urandom_range(9) != 0, 16'($urandom)));
    send_poll();
    if ($urandom_range(1) == 0)
      send_poll();
  endtask

  task automatic send_upload_session();
    int frames;
    logic [15:0] rlen;
    logic [15:0] mlen;
    frames = $urandom_range(6, 1);
    send_restart();
    repeat (frames) begin
      rlen = rand_len();
      case ($urandom_range(2))
        0: mlen = rlen;
        1: mlen = 16'($urandom_range(rlen));
        default: mlen = 16'($urandom);
      endcase
      send_request(make_req(OP_UPLOAD, rlen, $urandom_range(12) != 0, mlen));
      if ($urandom_range(3) == 0)
        send_poll();
      if ($urandom_range(19) == 0)
        send_request(rand_req());
    end
    send_poll();
  endtask

  // Error entry and recovery: clrstatus pairs, aborts and detach.
  task automatic send_recovery_session();
    send_request(make_req(OP_CLRSTATUS, 16'($urandom), 1'($urandom), 16'($urandom)));
    send_poll();
    if ($urandom_range(1) == 0)
      send_request(make_req(OP_ABORT, 16'($urandom), 1'($urandom), 16'($urandom)));
    send_request(make_req(OP_CLRSTATUS, 16'($urandom), 1'($urandom), 16'($urandom)));
    send_poll();
    if ($urandom_range(9) == 0)
      send_request(make_req(OP_DETACH, 16'($urandom), 1'($urandom), 16'($urandom)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Walk the state table: every operation, length and verdict extremes,
  // the short-frame rule, manifestation reporting and error recovery.
  task automatic test_directed();
    send_request(make_req(OP_GETSTATE,  16'd0,     1'b0, 16'd0));
    send_request(make_req(OP_GETSTATUS, 16'hFFFF,  1'b1, 16'hFFFF));
    send_request(make_req(OP_DNLOAD,    16'd0,     1'b1, 16'd5));      // idle: stall
    send_request(make_req(OP_DNLOAD,    16'hFFFF,  1'b0, 16'hFFFF));   // media refused
    send_request(make_req(OP_DNLOAD,    16'd16,    1'b1, 16'hFFFF));   // -> dnload sync
    send_request(make_req(OP_GETSTATUS, 16'd6,     1'b0, 16'd0));      // -> dnload idle
    send_request(make_req(OP_DNLOAD,    16'd1,     1'b1, 16'd0));      // next block
    send_request(make_req(OP_GETSTATUS, 16'd6,     1'b0, 16'd0));
    send_request(make_req(OP_DNLOAD,    16'd0,     1'b0, 16'd0));      // failed manifest
    send_request(make_req(OP_GETSTATUS, 16'd6,     1'b1, 16'd0));      // manifest, poll 1
    send_request(make_req(OP_UPLOAD,    16'hFFFF,  1'b1, 16'd0));      // short frame
    send_request(make_req(OP_UPLOAD,    16'd16,    1'b1, 16'd16));     // -> upload idle
    send_request(make_req(OP_UPLOAD,    16'd8,     1'b0, 16'd8));      // -> error, 0xF
    send_request(make_req(OP_GETSTATUS, 16'd0,     1'b0, 16'd0));
    send_request(make_req(OP_UPLOAD,    16'd8,     1'b1, 16'd8));      // error: stall
    send_request(make_req(OP_DNLOAD,    16'd8,     1'b1, 16'd8));      // error: stall
    send_request(make_req(OP_ABORT,     16'd0,     1'b0, 16'd0));      // no effect in error
    send_request(make_req(OP_CLRSTATUS, 16'd0,     1'b0, 16'd0));      // -> idle
    send_request(make_req(OP_CLRSTATUS, 16'hFFFF,  1'b1, 16'hFFFF));   // -> error, 0xE
    send_request(make_req(OP_UPLOAD,    16'd0,     1'b0, 16'd0));      // -> idle anywhere
    send_request(make_req(OP_UNKNOWN,   16'hFFFF,  1'b1, 16'hFFFF));   // stall
    send_request(make_req(OP_DNLOAD,    16'd2,     1'b1, 16'd2));
    send_request(make_req(OP_ABORT,     16'd0,     1'b1, 16'd0));      // dnload sync -> idle
    send_request(make_req(OP_DETACH,    16'd0,     1'b0, 16'd0));      // sticky flag
    send_request(make_req(OP_GETSTATE,  16'hFFFF,  1'b1, 16'hFFFF));
  endtask

  // Random sessions: mostly well-formed transfers, some recovery, some noise.
  task automatic test_mixed_traffic(int count);
    int stop_at;
    int pick;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35)
        send_download_session();
      else if (pick < 65)
        send_upload_session();
      else if (pick < 78)
        send_recovery_session();
      else
        repeat ($urandom_range(4, 1)) send_request(rand_req());
    end
  endtask

  // Reply side stalls for a long stretch while requests keep coming: the
  // reply register fills and the request channel must back up.
  task automatic test_reply_backpressure();
    req_idle_pct  = 0;
    rsp_idle_pct <= 0;
    hold_tickets <= hold_tickets + 1;
    repeat (40) send_request(rand_req());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    req_idle_pct  = 17;
    rsp_idle_pct <= 75;
    test_directed();
    test_mixed_traffic(600);

    req_idle_pct  = 75;
    rsp_idle_pct <= 17;
    test_mixed_traffic(550);

    test_reply_backpressure();

    req_idle_pct  = 0;
    rsp_idle_pct <= 0;
    test_mixed_traffic(550);

    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_replies.size() != 0) begin
      fail_count++;
      $display("[%0t] %0d replies never arrived", $realtime, pending_replies.size());
    end

    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dfu_rsm_pkg.sv
rtl/core/dfu_request_state_machine.sv
tb/sv/tb.sv
